// ===== design/kfr_pkg.sv =====
// Shared types, codes and helper functions for the diagnostic line receive framer.
`default_nettype none

package kfr_pkg;

    // Input item actions
    typedef enum logic [1:0] {
        ACT_ARM  = 2'd0,
        ACT_BYTE = 2'd1,
        ACT_TICK = 2'd2
    } t_action;

    // Result kinds
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // End report status codes
    localparam logic STATUS_FRAME   = 1'b0;
    localparam logic STATUS_TIMEOUT = 1'b1;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN   = 2'd1;

    // Configuration reset values
    localparam logic [7:0] GAP_LIMIT_RST = 8'd35;
    localparam logic [7:0] MAX_LEN_RST   = 8'd255;

    // Saturation limits
    localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;
    localparam logic [7:0]  GAP_MAX     = 8'hFF;

    // Result queue geometry
    localparam int unsigned OUT_DEPTH = 4;
    localparam int unsigned OUT_PTR_W = 2;
    localparam int unsigned OUT_CNT_W = 3;

    typedef struct packed {
        logic       kind;
        logic [7:0] byte_value;
        logic [7:0] byte_index;
        logic [7:0] frame_length;
        logic       status;
        logic       checksum_ok;
        logic       last;
    } t_result;

    function automatic t_result data_result(input logic [7:0] value, input logic [7:0] index);
        t_result r;
        r.kind         = KIND_DATA;
        r.byte_value   = value;
        r.byte_index   = index;
        r.frame_length = 8'd0;
        r.status       = STATUS_FRAME;
        r.checksum_ok  = 1'b0;
        r.last         = 1'b0;
        return r;
    endfunction

    function automatic t_result end_result(input logic [7:0] len, input logic [7:0] sum);
        t_result r;
        r.kind         = KIND_END;
        r.byte_value   = 8'd0;
        r.byte_index   = 8'd0;
        r.frame_length = len;
        r.status       = (len == 8'd0) ? STATUS_TIMEOUT : STATUS_FRAME;
        r.checksum_ok  = (len >= 8'd2) && (sum == 8'd0);
        r.last         = 1'b1;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/kline_frame_receiver.sv =====
// Receive framer for a single-wire diagnostic line: arm, byte and tick items in, reports out.
// Results of an item are registered into the queue on its input transfer and presented oldest first;
// at the end of a full-length frame a second result, the end report, is queued right behind the first.
// Throughput: one item per cycle; results wait in a four-entry queue, and input ready
// drops while fewer than two slots are free, so only a slow consumer throttles input.
// Reset (synchronous, active low) disarms the framer, empties the queue and restores
// gap_limit_ms to 35 and max_frame_len to 255.
`default_nettype none

module kline_frame_receiver
    import kfr_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,

    // configuration write channel
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [7:0]           i_cfg_data,

    // input item channel
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [1:0]           i_action,
    input  wire logic [7:0]           i_rx_byte,
    input  wire logic [15:0]          i_timeout_ms,

    // result channel
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic                      o_kind,
    output logic [7:0]                o_byte_value,
    output logic [7:0]                o_byte_index,
    output logic [7:0]                o_frame_length,
    output logic                      o_status,
    output logic                      o_checksum_ok,
    output logic                      o_last
);

    // Configuration registers
    logic [7:0] r_gap_limit;
    logic [7:0] r_max_len;

    // Framer state
    logic        r_armed,       n_armed;
    logic        r_started,     n_started;
    logic [7:0]  r_byte_count,  n_byte_count;
    logic [7:0]  r_running_sum, n_running_sum;
    logic [15:0] r_elapsed_ms,  n_elapsed_ms;
    logic [7:0]  r_gap_ms,      n_gap_ms;
    logic [15:0] r_timeout_lim, n_timeout_lim;

    // Result queue
    t_result              r_queue [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [OUT_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [OUT_CNT_W-1:0] r_count,  n_count;

    // Results produced by the current transfer
    t_result    res0;
    t_result    res1;
    logic [1:0] push_cnt;

    logic        in_xfer;
    logic        out_xfer;
    logic [7:0]  cnt_inc;
    logic [7:0]  sum_inc;
    logic [15:0] elapsed_inc;
    logic [7:0]  gap_inc;

    // Configuration is always taken at once
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap_limit <= GAP_LIMIT_RST;
            r_max_len   <= MAX_LEN_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_GAP_LIMIT: r_gap_limit <= i_cfg_data;
                CFG_MAX_LEN:   r_max_len   <= i_cfg_data;
                default: ;     // drop writes to unknown registers
            endcase
        end
    end

    // Accept a new item only when both possible results fit in the queue
    assign o_in_ready = (r_count <= OUT_CNT_W'(OUT_DEPTH - 2));
    assign in_xfer    = i_in_valid && o_in_ready;
    assign out_xfer   = o_out_valid && i_out_ready;

    assign cnt_inc     = r_byte_count + 8'd1;
    assign sum_inc     = r_running_sum + i_rx_byte;
    assign elapsed_inc = (r_elapsed_ms != ELAPSED_MAX) ? r_elapsed_ms + 16'd1 : r_elapsed_ms;
    assign gap_inc     = (r_started && r_gap_ms != GAP_MAX) ? r_gap_ms + 8'd1 : r_gap_ms;

    // Single pass over one item: update the framer and form its results
    always_comb begin
        n_armed       = r_armed;
        n_started     = r_started;
        n_byte_count  = r_byte_count;
        n_running_sum = r_running_sum;
        n_elapsed_ms  = r_elapsed_ms;
        n_gap_ms      = r_gap_ms;
        n_timeout_lim = r_timeout_lim;
        res0          = end_result(r_byte_count, r_running_sum);
        res1          = end_result(cnt_inc, sum_inc);
        push_cnt      = 2'd0;

        if (in_xfer) begin
            case (t_action'(i_action))
                ACT_ARM: begin
                    // re-arming drops any frame in progress without a report
                    n_armed       = 1'b1;
                    n_started     = 1'b0;
                    n_byte_count  = 8'd0;
                    n_running_sum = 8'd0;
                    n_elapsed_ms  = 16'd0;
                    n_gap_ms      = 8'd0;
                    n_timeout_lim = i_timeout_ms;
                    if (i_timeout_ms == 16'd0) begin
                        // zero timeout: report an empty timed-out frame at once
                        res0     = end_result(8'd0, 8'd0);
                        push_cnt = 2'd1;
                        n_armed  = 1'b0;
                    end
                end
                ACT_BYTE: begin
                    // zero bytes before the first real byte are break noise
                    if (r_armed && (r_started || i_rx_byte != 8'd0)) begin
                        res0          = data_result(i_rx_byte, r_byte_count);
                        push_cnt      = 2'd1;
                        n_started     = 1'b1;
                        n_byte_count  = cnt_inc;
                        n_running_sum = sum_inc;
                        n_gap_ms      = 8'd0;
                        if (cnt_inc >= r_max_len) begin
                            push_cnt  = 2'd2;
                            n_armed   = 1'b0;
                            n_started = 1'b0;
                        end
                    end
                end
                ACT_TICK: begin
                    if (r_armed) begin
                        n_elapsed_ms = elapsed_inc;
                        n_gap_ms     = gap_inc;
                        if ((r_started && gap_inc > r_gap_limit) ||
                            elapsed_inc >= r_timeout_lim) begin
                            push_cnt  = 2'd1;
                            n_armed   = 1'b0;
                            n_started = 1'b0;
                        end
                    end
                end
                default: ;     // unknown action: ignore
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed       <= 1'b0;
            r_started     <= 1'b0;
            r_byte_count  <= 8'd0;
            r_running_sum <= 8'd0;
            r_elapsed_ms  <= 16'd0;
            r_gap_ms      <= 8'd0;
            r_timeout_lim <= 16'd0;
        end else begin
            r_armed       <= n_armed;
            r_started     <= n_started;
            r_byte_count  <= n_byte_count;
            r_running_sum <= n_running_sum;
            r_elapsed_ms  <= n_elapsed_ms;
            r_gap_ms      <= n_gap_ms;
            r_timeout_lim <= n_timeout_lim;
        end
    end

    // Queue pointers: push up to two, pop at most one per cycle
    always_comb begin
        n_wr_ptr = r_wr_ptr + OUT_PTR_W'(push_cnt);
        n_rd_ptr = out_xfer ? r_rd_ptr + OUT_PTR_W'(1) : r_rd_ptr;
        n_count  = r_count + OUT_CNT_W'(push_cnt) - OUT_CNT_W'(out_xfer);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Queue storage: first result at the write pointer, second one after it
    always_ff @(posedge i_clk) begin
        if (push_cnt != 2'd0) begin
            r_queue[r_wr_ptr] <= res0;
        end
        if (push_cnt == 2'd2) begin
            r_queue[r_wr_ptr + OUT_PTR_W'(1)] <= res1;
        end
    end

    // Present the oldest queued result
    assign o_out_valid    = (r_count != '0);
    assign o_kind         = r_queue[r_rd_ptr].kind;
    assign o_byte_value   = r_queue[r_rd_ptr].byte_value;
    assign o_byte_index   = r_queue[r_rd_ptr].byte_index;
    assign o_frame_length = r_queue[r_rd_ptr].frame_length;
    assign o_status       = r_queue[r_rd_ptr].status;
    assign o_checksum_ok  = r_queue[r_rd_ptr].checksum_ok;
    assign o_last         = r_queue[r_rd_ptr].last;

    // Queue occupancy never exceeds its depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= OUT_CNT_W'(OUT_DEPTH))
        else $error("result queue overflow");

    // Pointer distance matches the occupancy count whenever the queue is not full
    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != OUT_CNT_W'(OUT_DEPTH) |->
            OUT_PTR_W'(r_wr_ptr - r_rd_ptr) == r_count[OUT_PTR_W-1:0])
        else $error("queue pointers disagree with count");

    // An end report always carries last, a byte report never does
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_last == o_kind))
        else $error("last flag does not match result kind");

    // A frame cannot have started unless reception is armed
    a_started_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_started |-> r_armed)
        else $error("started without armed");

    // An end report issued after a transfer leaves the framer disarmed
    a_end_disarms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && push_cnt != 2'd0 && (res0.kind == KIND_END || push_cnt == 2'd2)) |=> !r_armed)
        else $error("framer still armed after end report");

endmodule

`default_nettype wire
